// ----- sv/bmc_pkg.sv -----
// ----------------------------------------------------------------------------
// bmc_pkg
// shared types, widths and calibration decode for the barometer compensation
// ----------------------------------------------------------------------------
package bmc_pkg;

	localparam int TW = 56;   // width of one shifted pressure term
	localparam int SW = 58;   // width of pressure partial sums
	localparam int EW = 82;   // width of a recombined split product
	localparam int NTERM = 11;

	// term slots
	localparam int TERM_P5  = 0;
	localparam int TERM_P6  = 1;
	localparam int TERM_P7  = 2;
	localparam int TERM_P8  = 3;
	localparam int TERM_P1  = 4;
	localparam int TERM_P2  = 5;
	localparam int TERM_P3  = 6;
	localparam int TERM_P4  = 7;
	localparam int TERM_P9  = 8;
	localparam int TERM_P10 = 9;
	localparam int TERM_P11 = 10;

	typedef enum logic [1:0] {
		REG_CAL_LOW  = 2'd0,
		REG_CAL_MID  = 2'd1,
		REG_CAL_HIGH = 2'd2
	} reg_index_t;

	typedef struct packed {
		logic        [15:0] t1;
		logic        [15:0] t2;
		logic signed [7:0]  t3;
		logic signed [16:0] p1;   // already offset by -2^14
		logic signed [16:0] p2;   // already offset by -2^14
		logic signed [7:0]  p3;
		logic signed [7:0]  p4;
		logic        [15:0] p5;
		logic        [15:0] p6;
		logic signed [7:0]  p7;
		logic signed [7:0]  p8;
		logic signed [15:0] p9;
		logic signed [7:0]  p10;
		logic signed [7:0]  p11;
	} coef_t;

	// temperature result handed to the pressure path
	typedef struct packed {
		logic signed [23:0] tq;
		logic               tsat;
		logic        [23:0] u;
	} temp_res_t;

	// floored pressure terms handed to the summing stages
	typedef struct packed {
		logic [NTERM-1:0][TW-1:0] term;
		logic signed [23:0]       tq;
		logic                     tsat;
	} terms_t;

	function automatic coef_t cal_decode(input logic [63:0] lo, input logic [63:0] mid,
			input logic [39:0] hi);
		logic [20:0][7:0] b;
		coef_t c;
		for (int k = 0; k < 8; k++) begin
			b[k]     = lo[8*k +: 8];
			b[k + 8] = mid[8*k +: 8];
		end
		for (int k = 0; k < 5; k++) begin
			b[k + 16] = hi[8*k +: 8];
		end
		c.t1  = {b[1], b[0]};
		c.t2  = {b[3], b[2]};
		c.t3  = $signed(b[4]);
		c.p1  = 17'($signed({b[6], b[5]})) - 17'sd16384;
		c.p2  = 17'($signed({b[8], b[7]})) - 17'sd16384;
		c.p3  = $signed(b[9]);
		c.p4  = $signed(b[10]);
		c.p5  = {b[12], b[11]};
		c.p6  = {b[14], b[13]};
		c.p7  = $signed(b[15]);
		c.p8  = $signed(b[16]);
		c.p9  = $signed({b[18], b[17]});
		c.p10 = $signed(b[19]);
		c.p11 = $signed(b[20]);
		return c;
	endfunction

endpackage

// ----- sv/barometer_compensation.sv -----
// ----------------------------------------------------------------------------
// barometer_compensation
// compensated temperature and pressure from raw 24-bit sensor readings
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  input     in         in_valid / in_stall    raw_temperature, raw_pressure
//  output    out        out_valid / out_stall  temperature_out, pressure_out,
//                                              saturated
//  config    in         cfg_we                 cfg_index, cfg_data
//
//  one request per cycle while out_stall is low; results pass through
//  four temperature stages, four product stages and two sum stages
//  each stage holds its own valid bit and loads whenever it is empty or the
//  stage after it moves, so bubbles close up and a request is taken while a
//  finished result still waits on out_stall
//  arst_n clears all valid bits and the calibration registers to zero
//  no clearing pass after reset
// ----------------------------------------------------------------------------
module barometer_compensation import bmc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// calibration write port
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [63:0]        cfg_data,
	// raw reading request
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [23:0]        raw_temperature,
	input  logic [23:0]        raw_pressure,
	// compensated result request
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [23:0] temperature_out,
	output logic        [22:0] pressure_out,
	output logic               saturated
);

	// calibration byte registers
	logic [63:0] cal_low_q;
	logic [63:0] cal_mid_q;
	logic [39:0] cal_high_q;

	// coefficients must only change while the pipeline is empty; the block does
	// not enforce this. decode is plain logic shared by temperature and product stages
	coef_t coef;

	// temperature segment to product segment
	logic      tv;
	logic      tstall;
	temp_res_t tres;

	// product segment to sum segment
	logic   mv;
	logic   mstall;
	terms_t mres;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_low_q  <= '0;
			cal_mid_q  <= '0;
			cal_high_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CAL_LOW:  cal_low_q  <= cfg_data;
				REG_CAL_MID:  cal_mid_q  <= cfg_data;
				REG_CAL_HIGH: cal_high_q <= cfg_data[39:0];
				default: ;   // unknown index: write dropped
			endcase
		end
	end

	assign coef = cal_decode(cal_low_q, cal_mid_q, cal_high_q);

	// d = uT - 256*T1, then d*T2*2^18 + d^2*T3, round and clip
	bmc_temp u_temp (
		.clk       (clk),
		.arst_n    (arst_n),
		.coef      (coef),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.raw_t     (raw_temperature),
		.raw_p     (raw_pressure),
		.res_valid (tv),
		.res_stall (tstall),
		.res       (tres)
	);

	// eleven polynomial terms, each floored to 2^-32 Pa
	bmc_pmul u_pmul (
		.clk       (clk),
		.arst_n    (arst_n),
		.coef      (coef),
		.in_valid  (tv),
		.in_stall  (tstall),
		.tin       (tres),
		.res_valid (mv),
		.res_stall (mstall),
		.res       (mres)
	);

	// sum, round to 1/64 Pa, clip, output register
	bmc_psum u_psum (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (mv),
		.in_stall        (mstall),
		.tin             (mres),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.temperature_out (temperature_out),
		.pressure_out    (pressure_out),
		.saturated       (saturated)
	);

endmodule

// ----- sv/bmc_temp.sv -----
// ----------------------------------------------------------------------------
// bmc_temp
// four-stage temperature polynomial with rounding and saturation
// ----------------------------------------------------------------------------
module bmc_temp import bmc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  coef_t            coef,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [23:0]      raw_t,
	input  logic [23:0]      raw_p,
	output logic             res_valid,
	input  logic             res_stall,
	output temp_res_t        res
);

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic en_s1, en_s2, en_s3, en_s4;

	logic signed [24:0] d_s1;
	logic        [23:0] u_s1, u_s2, u_s3;
	logic signed [49:0] dd_s2;
	logic signed [41:0] dt2_s2, dt2_s3;
	logic signed [57:0] ddt3_s3;
	temp_res_t          res_s4;

	logic signed [61:0] t48;
	logic signed [29:0] tq_full;

	assign en_s4    = ~valid_s4 | ~res_stall;
	assign en_s3    = ~valid_s3 | en_s4;
	assign en_s2    = ~valid_s2 | en_s3;
	assign en_s1    = ~valid_s1 | en_s2;
	assign in_stall = ~en_s1;

	// rounded to 2^-16 degrees: add half, keep bits above 2^32
	assign t48     = (62'(dt2_s3) <<< 18) + 62'(ddt3_s3) + 62'sh80000000;
	assign tq_full = t48[61:32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= in_valid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
			if (en_s4) valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			d_s1 <= $signed({1'b0, raw_t}) - $signed({1'b0, coef.t1, 8'd0});
			u_s1 <= raw_p;
		end
		if (en_s2) begin
			dd_s2  <= d_s1 * d_s1;
			dt2_s2 <= d_s1 * $signed({1'b0, coef.t2});
			u_s2   <= u_s1;
		end
		if (en_s3) begin
			ddt3_s3 <= dd_s2 * coef.t3;
			dt2_s3  <= dt2_s2;
			u_s3    <= u_s2;
		end
		if (en_s4) begin
			res_s4.u <= u_s3;
			if (tq_full > 30'sd8388607) begin
				res_s4.tq   <= 24'sd8388607;
				res_s4.tsat <= 1'b1;
			end else if (tq_full < -30'sd8388608) begin
				res_s4.tq   <= -24'sd8388608;
				res_s4.tsat <= 1'b1;
			end else begin
				res_s4.tq   <= tq_full[23:0];
				res_s4.tsat <= 1'b0;
			end
		end
	end

	assign res_valid = valid_s4;
	assign res       = res_s4;

endmodule

// ----- sv/bmc_pmul.sv -----
// ----------------------------------------------------------------------------
// bmc_pmul
// four-stage product tree for the eleven pressure terms
// ----------------------------------------------------------------------------
module bmc_pmul import bmc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  coef_t      coef,
	input  logic       in_valid,
	output logic       in_stall,
	input  temp_res_t  tin,
	output logic       res_valid,
	input  logic       res_stall,
	output terms_t     res
);

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic en_s1, en_s2, en_s3, en_s4;

	// stage 1: first-level products
	logic signed [47:0] tsq_s1;
	logic        [47:0] u2_s1;
	logic signed [40:0] a6_s1;
	logic signed [41:0] a1_s1, up2_s1;
	logic signed [32:0] up3_s1, up4_s1, up11_s1;
	logic signed [31:0] p8t_s1, p10t_s1;
	logic signed [23:0] tq_s1;
	logic               tsat_s1;

	// stage 2: second-level products, wide ones split in halves
	logic signed [55:0] e7_s2;
	logic signed [56:0] pp8h_s2, pp8l_s2;
	logic signed [65:0] e2_s2;
	logic signed [57:0] pp3h_s2, pp3l_s2;
	logic signed [56:0] up4t_s2;
	logic signed [64:0] e9_s2;
	logic signed [56:0] pp10h_s2, pp10l_s2;
	logic signed [57:0] pp11h_s2, pp11l_s2;
	logic signed [47:0] tsq_s2;
	logic signed [40:0] a6_s2;
	logic signed [41:0] a1_s2;
	logic signed [23:0] tq_s2;
	logic               tsat_s2;

	// stage 3: recombined and floored terms, cubic term still in pieces
	logic [NTERM-1:0][TW-1:0] term_s3;
	logic signed [73:0]       q0_s3, q1_s3, q2_s3;
	logic signed [23:0]       tq_s3;
	logic                     tsat_s3;

	terms_t res_s4;

	logic signed [24:0] tsq_lo, tsq_hi, u2_lo, u2_hi;
	logic signed [16:0] c0, c1, c2;
	logic signed [24:0] u_s;
	logic signed [EW-1:0] e8, e3, e10, e11;
	logic signed [105:0]  e4;
	logic [NTERM-1:0][TW-1:0] term_mix;

	assign en_s4    = ~valid_s4 | ~res_stall;
	assign en_s3    = ~valid_s3 | en_s4;
	assign en_s2    = ~valid_s2 | en_s3;
	assign en_s1    = ~valid_s1 | en_s2;
	assign in_stall = ~en_s1;

	assign u_s    = $signed({1'b0, tin.u});
	assign tsq_lo = $signed({1'b0, tsq_s1[23:0]});
	assign tsq_hi = $signed({1'b0, tsq_s1[47:24]});
	assign u2_lo  = $signed({1'b0, u2_s1[23:0]});
	assign u2_hi  = $signed({1'b0, u2_s1[47:24]});
	assign c0     = $signed({1'b0, tsq_s2[15:0]});
	assign c1     = $signed({1'b0, tsq_s2[31:16]});
	assign c2     = $signed({1'b0, tsq_s2[47:32]});

	assign e8  = (EW'(pp8h_s2) <<< 24) + EW'(pp8l_s2);
	assign e3  = (EW'(pp3h_s2) <<< 24) + EW'(pp3l_s2);
	assign e10 = (EW'(pp10h_s2) <<< 24) + EW'(pp10l_s2);
	assign e11 = (EW'(pp11h_s2) <<< 24) + EW'(pp11l_s2);
	assign e4  = (106'(q2_s3) <<< 32) + (106'(q1_s3) <<< 16) + 106'(q0_s3);

	// cubic term joins the others on the way into the last stage
	always_comb begin
		term_mix          = term_s3;
		term_mix[TERM_P4] = TW'(e4 >>> 53);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= in_valid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
			if (en_s4) valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			tsq_s1  <= tin.tq * tin.tq;
			u2_s1   <= tin.u * tin.u;
			a6_s1   <= $signed({1'b0, coef.p6}) * tin.tq;
			a1_s1   <= u_s * coef.p1;
			up2_s1  <= u_s * coef.p2;
			up3_s1  <= u_s * coef.p3;
			up4_s1  <= u_s * coef.p4;
			up11_s1 <= u_s * coef.p11;
			p8t_s1  <= coef.p8 * tin.tq;
			p10t_s1 <= coef.p10 * tin.tq;
			tq_s1   <= tin.tq;
			tsat_s1 <= tin.tsat;
		end
		if (en_s2) begin
			e7_s2    <= 56'(coef.p7) * tsq_s1;
			pp8h_s2  <= p8t_s1 * tsq_hi;
			pp8l_s2  <= p8t_s1 * tsq_lo;
			e2_s2    <= up2_s1 * tq_s1;
			pp3h_s2  <= up3_s1 * tsq_hi;
			pp3l_s2  <= up3_s1 * tsq_lo;
			up4t_s2  <= up4_s1 * tq_s1;
			e9_s2    <= $signed({1'b0, u2_s1}) * coef.p9;
			pp10h_s2 <= p10t_s1 * u2_hi;
			pp10l_s2 <= p10t_s1 * u2_lo;
			pp11h_s2 <= up11_s1 * u2_hi;
			pp11l_s2 <= up11_s1 * u2_lo;
			tsq_s2   <= tsq_s1;
			a6_s2    <= a6_s1;
			a1_s2    <= a1_s1;
			tq_s2    <= tq_s1;
			tsat_s2  <= tsat_s1;
		end
		if (en_s3) begin
			term_s3[TERM_P5]  <= $signed(TW'({coef.p5, 35'd0}));
			term_s3[TERM_P6]  <= TW'(a6_s2) <<< 10;
			term_s3[TERM_P7]  <= TW'(e7_s2 >>> 8);
			term_s3[TERM_P8]  <= TW'(e8 >>> 31);
			term_s3[TERM_P1]  <= TW'(a1_s2) <<< 12;
			term_s3[TERM_P2]  <= TW'(e2_s2 >>> 13);
			term_s3[TERM_P3]  <= TW'(e3 >>> 32);
			term_s3[TERM_P4]  <= '0;
			term_s3[TERM_P9]  <= TW'(e9_s2 >>> 16);
			term_s3[TERM_P10] <= TW'(e10 >>> 32);
			term_s3[TERM_P11] <= TW'(e11 >>> 33);
			q0_s3   <= up4t_s2 * c0;
			q1_s3   <= up4t_s2 * c1;
			q2_s3   <= up4t_s2 * c2;
			tq_s3   <= tq_s2;
			tsat_s3 <= tsat_s2;
		end
		if (en_s4) begin
			res_s4.term <= term_mix;
			res_s4.tq   <= tq_s3;
			res_s4.tsat <= tsat_s3;
		end
	end

	assign res_valid = valid_s4;
	assign res       = res_s4;

endmodule

// ----- sv/bmc_psum.sv -----
// ----------------------------------------------------------------------------
// bmc_psum
// two-stage term sum, rounding and saturation, doubles as output register
// ----------------------------------------------------------------------------
module bmc_psum import bmc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  terms_t             tin,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [23:0] temperature_out,
	output logic        [22:0] pressure_out,
	output logic               saturated
);

	logic valid_s1, valid_s2;
	logic en_s1, en_s2;

	logic signed [SW-1:0] sa_s1, sb_s1, sc_s1;
	logic signed [23:0]   tq_s1;
	logic                 tsat_s1;

	logic signed [23:0] tq_s2;
	logic        [22:0] pq_s2;
	logic               sat_s2;

	logic signed [SW-1:0] acc;
	logic signed [31:0]   pq_full;

	function automatic logic signed [SW-1:0] tx(input logic [TW-1:0] v);
		return SW'($signed(v));
	endfunction

	assign en_s2    = ~valid_s2 | ~out_stall;
	assign en_s1    = ~valid_s1 | en_s2;
	assign in_stall = ~en_s1;

	// round to 1/64 Pa: add half, keep bits above 2^26
	assign acc     = sa_s1 + sb_s1 + sc_s1 + SW'(33554432);
	assign pq_full = acc[57:26];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= in_valid;
			if (en_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			sa_s1 <= tx(tin.term[TERM_P5]) + tx(tin.term[TERM_P6])
				+ tx(tin.term[TERM_P7]) + tx(tin.term[TERM_P8]);
			sb_s1 <= tx(tin.term[TERM_P1]) + tx(tin.term[TERM_P2])
				+ tx(tin.term[TERM_P3]) + tx(tin.term[TERM_P4]);
			sc_s1 <= tx(tin.term[TERM_P9]) + tx(tin.term[TERM_P10])
				+ tx(tin.term[TERM_P11]);
			tq_s1   <= tin.tq;
			tsat_s1 <= tin.tsat;
		end
		if (en_s2) begin
			tq_s2 <= tq_s1;
			if (pq_full < 32'sd0) begin
				pq_s2  <= '0;
				sat_s2 <= 1'b1;
			end else if (pq_full > 32'sd8388607) begin
				pq_s2  <= '1;
				sat_s2 <= 1'b1;
			end else begin
				pq_s2  <= pq_full[22:0];
				sat_s2 <= tsat_s1;
			end
		end
	end

	assign out_valid       = valid_s2;
	assign temperature_out = tq_s2;
	assign pressure_out    = pq_s2;
	assign saturated       = sat_s2;

endmodule

// ----- tb/tb_barometer_compensation.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_barometer_compensation
// self-checking bench for the barometer compensation pipeline
// ----------------------------------------------------------------------------
// raw readings are queued by the stimulus process and sent by a clocked
// driver with random idle bursts. every accepted request is run through an
// exact wide-integer model of the compensation polynomials, and a clocked
// monitor with random stall bursts checks each result in order. the run
// steps through several calibration sets, written only while the pipeline
// is empty.
// ----------------------------------------------------------------------------
module tb_barometer_compensation;
	import bmc_pkg::*;

	localparam logic [1:0] REG_UNUSED = 2'd3;   // no register behind this index
	localparam int LATENCY   = 12;
	localparam int IDLE_STOP = 4000;             // cycles with no progress

	typedef struct {
		logic [23:0] raw_t;
		logic [23:0] raw_p;
	} reading_t;

	typedef struct {
		logic [23:0] temp;
		logic [22:0] press;
		logic        sat;
	} comp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = REG_CAL_LOW;
	logic [63:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [23:0] raw_temperature = '0;
	logic [23:0] raw_pressure = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [23:0] temperature_out;
	logic [22:0] pressure_out;
	logic saturated;

	barometer_compensation uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.raw_temperature(raw_temperature), .raw_pressure(raw_pressure),
		.out_valid(out_valid), .out_stall(out_stall),
		.temperature_out(temperature_out), .pressure_out(pressure_out),
		.saturated(saturated)
	);

	always #5 clk = ~clk;

	// shadow of the calibration registers
	logic [63:0] cal_lo = '0, cal_mid = '0;
	logic [39:0] cal_hi = '0;

	reading_t pending_readings[$];
	comp_t expected_results[$];
	int errors = 0;
	bit quiet = 0;          // no idling on either side in the last phase
	int idle_cycles = 0;
	bit progress;

	// exact compensation of one reading with the current calibration
	function automatic comp_t compensate(input logic [23:0] ut, input logic [23:0] up);
		logic [7:0] b[21];
		logic signed [159:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, p10, p11;
		logic signed [159:0] uts, u, u2, d, t48, tq, tsq, acc, pq;
		comp_t r;
		for (int k = 0; k < 8; k++) begin
			b[k] = cal_lo[8*k +: 8];
			b[k+8] = cal_mid[8*k +: 8];
		end
		for (int k = 0; k < 5; k++)
			b[k+16] = cal_hi[8*k +: 8];
		t1 = {b[1], b[0]};
		t2 = {b[3], b[2]};
		t3 = $signed(b[4]);
		p1 = $signed({b[6], b[5]});
		p1 = p1 - 16384;
		p2 = $signed({b[8], b[7]});
		p2 = p2 - 16384;
		p3 = $signed(b[9]);
		p4 = $signed(b[10]);
		p5 = {b[12], b[11]};
		p6 = {b[14], b[13]};
		p7 = $signed(b[15]);
		p8 = $signed(b[16]);
		p9 = $signed({b[18], b[17]});
		p10 = $signed(b[19]);
		p11 = $signed(b[20]);
		uts = ut;
		u = up;
		r.sat = 1'b0;

		// temperature, rounded to 2^-16 C and clipped
		d = uts - t1 * 256;
		t48 = d * t2 * 262144 + d * d * t3;
		tq = (t48 + 64'sd2147483648) >>> 32;
		if (tq > 8388607) begin
			tq = 8388607;
			r.sat = 1'b1;
		end
		if (tq < -8388608) begin
			tq = -8388608;
			r.sat = 1'b1;
		end

		// pressure terms in 2^-32 Pa, each floored on its own
		tsq = tq * tq;
		u2 = u * u;
		acc = p5 <<< 35;
		acc = acc + p6 * tq * 1024;
		acc = acc + ((p7 * tsq) >>> 8);
		acc = acc + ((p8 * tq * tsq) >>> 31);
		acc = acc + u * p1 * 4096;
		acc = acc + ((u * p2 * tq) >>> 13);
		acc = acc + ((u * p3 * tsq) >>> 32);
		acc = acc + ((u * p4 * tq * tsq) >>> 53);
		acc = acc + ((u2 * p9) >>> 16);
		acc = acc + ((u2 * p10 * tq) >>> 32);
		acc = acc + ((u2 * u * p11) >>> 33);
		pq = (acc + 33554432) >>> 26;
		if (pq < 0) begin
			pq = 0;
			r.sat = 1'b1;
		end
		if (pq > 8388607) begin
			pq = 8388607;
			r.sat = 1'b1;
		end
		r.temp = tq[23:0];
		r.press = pq[22:0];
		return r;
	endfunction

	// driver: takes the next reading from the queue, idles in bursts
	int send_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		reading_t rd;
		logic next_valid;
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap = 0;
		end else begin
			if (in_valid && !in_stall)
				expected_results.push_back(compensate(raw_temperature, raw_pressure));
			next_valid = in_valid;
			if (!(in_valid && in_stall)) begin
				next_valid = 1'b0;
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending_readings.size() > 0) begin
					rd = pending_readings.pop_front();
					raw_temperature <= rd.raw_t;
					raw_pressure <= rd.raw_p;
					next_valid = 1'b1;
					if (!quiet && $urandom_range(0, 9) == 0)
						send_gap = $urandom_range(1, 12);
				end
			end
			in_valid <= next_valid;
		end
	end

	// monitor: checks results in order, stalls in bursts
	int stall_left = 0;
	always @(posedge clk or negedge arst_n) begin
		comp_t e;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t: result with no request pending: temp %h press %h sat %b",
						$time, temperature_out, pressure_out, saturated);
				end else begin
					e = expected_results.pop_front();
					if (temperature_out !== e.temp) begin
						errors++;
						$display("%0t: temperature_out expected %h actual %h",
							$time, e.temp, temperature_out);
					end
					if (pressure_out !== e.press) begin
						errors++;
						$display("%0t: pressure_out expected %h actual %h",
							$time, e.press, pressure_out);
					end
					if (saturated !== e.sat) begin
						errors++;
						$display("%0t: saturated expected %b actual %b",
							$time, e.sat, saturated);
					end
				end
			end
			if (stall_left > 0)
				stall_left--;
			else if (!quiet && $urandom_range(0, 9) == 0)
				stall_left = $urandom_range(1, 12);
			out_stall <= (stall_left > 0);
		end
	end

	// watchdog on cycles where no request moves on either side and no calibration write happens
	always @(posedge clk) begin
		progress = (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we;
		if (progress || !arst_n)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_STOP) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_CAL_LOW: cal_lo = data;
			REG_CAL_MID: cal_mid = data;
			REG_CAL_HIGH: cal_hi = data[39:0];
			default: ;
		endcase
	endtask

	// all three calibration words; junk above the top word's width and a
	// write to the unused index must both be ignored
	task automatic load_cal(input logic [63:0] lo, input logic [63:0] mid,
			input logic [39:0] hi);
		write_reg(REG_CAL_LOW, lo);
		write_reg(REG_CAL_MID, mid);
		write_reg(REG_CAL_HIGH, {$urandom(), $urandom()} & 64'hFFFFFF0000000000 | hi);
		write_reg(REG_UNUSED, {$urandom(), $urandom()});
	endtask

	// sender pauses until the pipeline has drained, then waits out latency
	task automatic drain;
		do @(negedge clk);
		while (pending_readings.size() > 0 || in_valid || expected_results.size() > 0);
		repeat (LATENCY) @(posedge clk);
	endtask

	task automatic queue_reading(input logic [23:0] t, input logic [23:0] p);
		reading_t rd;
		rd.raw_t = t;
		rd.raw_p = p;
		pending_readings.push_back(rd);
	endtask

	// mostly readings near the calibration point, some anywhere
	task automatic queue_random(input int n);
		logic [23:0] t, p;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 3) == 0) begin
				t = 24'($urandom());
				p = 24'($urandom());
			end else begin
				t = {cal_lo[15:0], 8'h00} + 24'($urandom_range(0, 1 << 20)) - 24'(1 << 19);
				p = 24'($urandom_range(4000000, 9000000));
			end
			queue_reading(t, p);
		end
	endtask

	// plausible calibration: t1 27500, t2 19000, t3 -10, p1 2000, p2 2500,
	// p3 35, p4 0, p5 25000, p6 30000, p7 4, p8 -10, p9 3000, p10 5, p11 -60
	logic [63:0] typ_mid;
	logic [39:0] typ_hi;

	initial begin
		logic [20:0][7:0] cb;
		cb = '0;
		{cb[1], cb[0]} = 16'd27500;
		{cb[3], cb[2]} = 16'd19000;
		cb[4] = -8'sd10;
		{cb[6], cb[5]} = 16'd2000;
		{cb[8], cb[7]} = 16'd2500;
		cb[9] = 8'd35;
		cb[10] = 8'd0;
		{cb[12], cb[11]} = 16'd25000;
		{cb[14], cb[13]} = 16'd30000;
		cb[15] = 8'd4;
		cb[16] = -8'sd10;
		{cb[18], cb[17]} = 16'd3000;
		cb[19] = 8'd5;
		cb[20] = -8'sd60;
		typ_mid = cb[15:8];
		typ_hi = cb[20:16];

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// reset calibration: all calibration bytes zero
		queue_reading(24'h000000, 24'h000000);
		queue_reading(24'hFFFFFF, 24'hFFFFFF);
		drain();

		// typical calibration with directed corners
		load_cal(cb[7:0], typ_mid, typ_hi);
		queue_reading(24'h000000, 24'h000000);
		queue_reading(24'hFFFFFF, 24'hFFFFFF);
		queue_reading(24'h000000, 24'hFFFFFF);
		queue_reading(24'hFFFFFF, 24'h000000);
		queue_reading(24'h800000, 24'h7FFFFF);
		queue_reading(24'h7FFFFF, 24'h800000);
		queue_reading({cb[1], cb[0], 8'h00}, 24'd6500000);   // zero temperature offset
		queue_reading({cb[1], cb[0], 8'h00} + 24'd1, 24'd1);
		queue_reading({cb[1], cb[0], 8'h00} - 24'd1, 24'd8000000);
		queue_reading(24'h555555, 24'hAAAAAA);
		queue_reading(24'hAAAAAA, 24'h555555);
		queue_random(100);
		drain();

		// every byte all ones, then at its most positive, then at its most negative
		load_cal(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 40'hFF_FFFF_FFFF);
		queue_reading(24'h000000, 24'h000000);
		queue_reading(24'hFFFFFF, 24'hFFFFFF);
		queue_random(60);
		drain();
		load_cal(64'h7F7F_7F7F_7F7F_7F7F, 64'h7F7F_7F7F_7F7F_7F7F, 40'h7F_7F7F_7F7F);
		queue_reading(24'hFFFFFF, 24'hFFFFFF);
		queue_random(60);
		drain();
		load_cal(64'h8080_8080_8080_8080, 64'h8080_8080_8080_8080, 40'h80_8080_8080);
		queue_reading(24'h000000, 24'hFFFFFF);
		queue_random(60);
		drain();

		// random calibration sets
		for (int ph = 0; ph < 3; ph++) begin
			load_cal({$urandom(), $urandom()}, {$urandom(), $urandom()},
				{8'($urandom()), 32'($urandom())});
			queue_random(50);
			drain();
		end

		// typical set again, flat out on both sides
		load_cal(cb[7:0], typ_mid, typ_hi);
		quiet = 1;
		queue_random(80);
		drain();

		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
